@@ hw/rtl/crlf_dec_pkg.sv @@
// Package for the CRLF line command decoder.
// Holds the line event record, status codes, character constants and the
// command decode helpers. No dependencies.
`timescale 1ns / 1ps

package crlf_dec_pkg;

  // Header bytes kept from the start of each line
  localparam int unsigned HDR_LEN = 10;

  // Status codes of a result item
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BAD_LF   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Characters
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_F    = 8'h46;

  typedef logic [7:0] hdr_byte_t;
  typedef hdr_byte_t [HDR_LEN-1:0] header_t;

  // Firmware update keyword, byte 9 first
  localparam header_t UPDATE_WORD = {
    8'h61, 8'h74, 8'h61, 8'h64, 8'h70, 8'h75, 8'h5F, 8'h72, 8'h69, 8'h46
  };

  // One line event passed from the front end to the back end
  typedef struct packed {
    logic [1:0] status;
    header_t    header;
    logic [7:0] length;
  } line_event_t;

  // Command code from header bytes 0, 1 and 8
  function automatic logic [4:0] decode_command(input header_t hdr);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] digit;
    logic [4:0] code;
    b0    = hdr[0];
    b1    = hdr[1];
    digit = b1 - CH_ZERO;
    code  = 5'd0;
    if (hdr[8] == CH_F) begin
      if (b0 == CH_A && (b1 inside {[8'h31:8'h39]})) begin
        code = digit[4:0];
      end else if (b0 == CH_B && (b1 inside {[8'h31:8'h37]})) begin
        code = 5'd10 + digit[4:0];
      end else if (b0 == CH_C) begin
        if (b1 == CH_ZERO) begin
          code = 5'd30;
        end else if (b1 inside {8'h32, 8'h34, 8'h36, 8'h38}) begin
          code = 5'd20 + digit[4:0];
        end
      end
    end
    return code;
  endfunction

endpackage

@@ hw/rtl/crlf_dec_front.sv @@
// Front end: accepts received bytes, tracks CR/LF framing, byte count and
// the header store, and pushes one line event per completed or dropped line.
// Depends on crlf_dec_pkg.
`timescale 1ns / 1ps

module crlf_dec_front #(
  parameter int unsigned LINE_CAPACITY = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      byte_valid,
  input  logic [7:0]                byte_data,
  input  logic                      queue_full,
  output logic                      byte_stall,
  output logic                      ev_push,
  output crlf_dec_pkg::line_event_t ev_data
);

  localparam int unsigned CW = $clog2(LINE_CAPACITY);
  localparam int unsigned LW = (CW > 8) ? CW : 8;

  logic                  cr_r, cr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  crlf_dec_pkg::header_t hdr_r, hdr_nxt;
  logic                  accept;
  logic [LW-1:0]         cnt_ext;
  logic [7:0]            len_sat;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;

  // Line length saturates at 255 for long buffers
  assign cnt_ext = LW'(cnt_r);
  assign len_sat = (cnt_ext > LW'(255)) ? 8'hFF : cnt_ext[7:0];

  // Framing and store update
  always_comb begin
    cr_nxt  = cr_r;
    cnt_nxt = cnt_r;
    hdr_nxt = hdr_r;
    ev_push = 1'b0;
    ev_data.status = crlf_dec_pkg::ST_DONE;
    ev_data.header = hdr_r;
    ev_data.length = len_sat;
    if (accept) begin
      if (cr_r) begin
        cr_nxt  = 1'b0;
        cnt_nxt = '0;
        ev_push = 1'b1;
        if (byte_data != crlf_dec_pkg::CH_LF) begin
          ev_data.status = crlf_dec_pkg::ST_BAD_LF;
        end else begin
          hdr_nxt = '0;
        end
      end else if (byte_data == crlf_dec_pkg::CH_CR) begin
        cr_nxt = 1'b1;
      end else begin
        for (int i = 0; i < crlf_dec_pkg::HDR_LEN; i++) begin
          if (cnt_r == CW'(i)) begin
            hdr_nxt[i] = byte_data;
          end
        end
        if (cnt_r == CW'(LINE_CAPACITY - 1)) begin
          cnt_nxt        = '0;
          ev_push        = 1'b1;
          ev_data.status = crlf_dec_pkg::ST_OVERFLOW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r  <= 1'b0;
      cnt_r <= '0;
      hdr_r <= '0;
    end else begin
      cr_r  <= cr_nxt;
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
    end
  end

endmodule

@@ hw/rtl/crlf_dec_queue.sv @@
// Two-entry event queue between the front end and the back end.
// Depends on crlf_dec_pkg.
`timescale 1ns / 1ps

module crlf_dec_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  crlf_dec_pkg::line_event_t push_data,
  input  logic                      pop,
  output logic                      full,
  output logic                      not_empty,
  output crlf_dec_pkg::line_event_t head
);

  crlf_dec_pkg::line_event_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push;
  logic       do_pop;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head      = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/crlf_dec_back.sv @@
// Back end: decodes the queued line event into a result item and holds it
// in the output register until the receiver takes it.
// Depends on crlf_dec_pkg.
`timescale 1ns / 1ps

module crlf_dec_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ev_valid,
  input  crlf_dec_pkg::line_event_t ev_data,
  output logic                      ev_pop,
  input  logic                      res_stall,
  output logic                      res_valid,
  output logic [1:0]                res_status,
  output logic [4:0]                res_command_code,
  output logic                      res_update_request,
  output logic [15:0]               res_payload_word,
  output logic [7:0]                res_line_length
);

  logic        valid_r, valid_nxt;
  logic [1:0]  status_r;
  logic [4:0]  cmd_r, cmd_nxt;
  logic        upd_r, upd_nxt;
  logic [15:0] pay_r, pay_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        done;

  // Load a new result when the register is empty or being taken
  assign ev_pop = ev_valid && (!valid_r || !res_stall);
  assign done   = (ev_data.status == crlf_dec_pkg::ST_DONE);

  // Decode; drop results carry zero fields
  always_comb begin
    cmd_nxt = '0;
    upd_nxt = 1'b0;
    pay_nxt = '0;
    len_nxt = '0;
    if (done) begin
      cmd_nxt = crlf_dec_pkg::decode_command(ev_data.header);
      upd_nxt = (ev_data.header == crlf_dec_pkg::UPDATE_WORD);
      pay_nxt = {ev_data.header[2], ev_data.header[3]};
      len_nxt = ev_data.length;
    end
    valid_nxt = valid_r;
    if (ev_pop) begin
      valid_nxt = 1'b1;
    end else if (!res_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      status_r <= ev_data.status;
      cmd_r    <= cmd_nxt;
      upd_r    <= upd_nxt;
      pay_r    <= pay_nxt;
      len_r    <= len_nxt;
    end
  end

  assign res_valid          = valid_r;
  assign res_status         = status_r;
  assign res_command_code   = cmd_r;
  assign res_update_request = upd_r;
  assign res_payload_word   = pay_r;
  assign res_line_length    = len_r;

endmodule

@@ hw/rtl/crlf_line_command_decoder.sv @@
// CRLF line command decoder, top level.
// Input channel: one received byte per item (in_valid, in_stall, in_rx_byte).
// Each accepted byte updates the line state in the cycle it is taken; a new
// byte may be accepted every cycle while in_stall is low.
// A CR followed by LF completes a line and yields one result item with the
// decoded command code, firmware update flag, payload word and line length.
// A non-LF byte after CR, or a line reaching LINE_CAPACITY bytes, yields a
// drop status item. Other bytes yield no item.
// A result passes through the queue, written on the edge that accepts the byte
// causing it, and then the output register, loaded once it is empty or being taken.
// Throughput: one byte per cycle while in_stall is low.
// When the receiver holds out_stall, the result waits in the output register
// and the queue takes up to two more; in_stall rises only once it is full.
// Reset (synchronous, active low) clears the framing state, the byte count,
// the header store, the queue and the output valid.
// Depends on crlf_dec_pkg, crlf_dec_front, crlf_dec_queue, crlf_dec_back.
`timescale 1ns / 1ps

module crlf_line_command_decoder #(
  parameter int unsigned LINE_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_command_code,
  output logic        out_update_request,
  output logic [15:0] out_payload_word,
  output logic [7:0]  out_line_length
);

  logic                      ev_push;
  crlf_dec_pkg::line_event_t ev_in;
  logic                      q_full;
  logic                      q_valid;
  crlf_dec_pkg::line_event_t q_head;
  logic                      q_pop;

  crlf_dec_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(in_valid),
    .byte_data (in_rx_byte),
    .queue_full(q_full),
    .byte_stall(in_stall),
    .ev_push   (ev_push),
    .ev_data   (ev_in)
  );

  crlf_dec_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (ev_push),
    .push_data(ev_in),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (q_head)
  );

  crlf_dec_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev_valid          (q_valid),
    .ev_data           (q_head),
    .ev_pop            (q_pop),
    .res_stall         (out_stall),
    .res_valid         (out_valid),
    .res_status        (out_status),
    .res_command_code  (out_command_code),
    .res_update_request(out_update_request),
    .res_payload_word  (out_payload_word),
    .res_line_length   (out_line_length)
  );

endmodule
